@@ hw/rtl/fua_pkg.sv @@
// ----------------------------------------------------------------------------
// fua_pkg
// Shared types and constants for the AVC FU-A packetizer.
// ----------------------------------------------------------------------------
package fua_pkg;

	localparam int QDepth = 4;
	localparam int QAw    = $clog2(QDepth);

	localparam logic [15:0] MTU_RESET    = 16'd1400;
	localparam logic [2:0]  PREFIX_RESET = 3'd4;

	localparam logic [7:0] NRI_MASK  = 8'he0;
	localparam logic [7:0] FU_A_TYPE = 8'd28;
	localparam logic [7:0] TYPE_MASK = 8'h1f;
	localparam logic [7:0] FU_S_BIT  = 8'h80;
	localparam logic [7:0] FU_E_BIT  = 8'h40;

	typedef enum logic [0:0] {
		REG_MTU    = 1'b0,
		REG_PREFIX = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_PREFIX  = 2'd0,
		PH_NAL     = 2'd1,
		PH_SKIP    = 2'd2,
		PH_DISCARD = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        frame_start;
		logic [31:0] frame_length;
	} in_item_t;

	typedef struct packed {
		logic [7:0] packet_byte;
		logic       packet_end;
		logic       is_fragment;
	} out_item_t;

	// one queue entry: a payload byte, optionally preceded by the two FU-A headers
	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] fu_ind;
		logic [7:0] fu_hdr;
		logic       with_hdr;
		logic       last;
		logic       frag;
	} op_t;

endpackage

@@ hw/rtl/fua_front.sv @@
// ----------------------------------------------------------------------------
// fua_front
// Length-prefix parser: tracks NAL boundaries and fragment fill, one byte
// per transfer, and issues one op per output byte group.
// ----------------------------------------------------------------------------
module fua_front import fua_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  in_item_t    item,
	input  logic [15:0] mtu_q,
	input  logic [2:0]  prefix_q,
	output logic        push,
	output op_t         op
);

	phase_t      phase_q, phase_d, ph_e;
	logic [2:0]  pcnt_q, pcnt_e, pcnt_d;
	logic [31:0] acc_q, acc_e, acc_d;
	logic [31:0] rem_q, rem_e, rem_d;
	logic [31:0] idx_q, idx_d;
	logic [31:0] total_q, total_e;
	logic [15:0] fill_q, fill_e, fill_d;
	logic [7:0]  ind_q, ind_d;
	logic [4:0]  type_q, type_d;
	logic        first_q, first_e, first_d;
	logic        fragm_q, fragm_e, fragm_d;
	logic        hp_q, hp_e, hp_d;

	logic [31:0] acc_new, rem_dec, sz;
	logic [2:0]  pcnt_new, psize;
	logic [15:0] cap, fill_inc;
	logic        pos_past, prefix_done, nal_done;

	// frame start restarts the parse
	always_comb begin
		total_e = item.frame_start ? item.frame_length : total_q;
		ph_e    = item.frame_start ? PH_PREFIX : phase_q;
		pcnt_e  = item.frame_start ? 3'd0 : pcnt_q;
		acc_e   = item.frame_start ? 32'd0 : acc_q;
		rem_e   = item.frame_start ? 32'd0 : rem_q;
		fill_e  = item.frame_start ? 16'd0 : fill_q;
		fragm_e = item.frame_start ? 1'b0 : fragm_q;
		hp_e    = item.frame_start ? 1'b0 : hp_q;
		first_e = item.frame_start ? 1'b1 : first_q;
	end

	always_comb begin
		logic [31:0] pos;
		pos      = item.frame_start ? 32'd0 : idx_q;
		idx_d    = (pos != 32'hffff_ffff) ? pos + 32'd1 : pos;
		pos_past = (pos >= total_e);
		psize    = (prefix_q == 3'd0) ? 3'd1 : ((prefix_q > 3'd4) ? 3'd4 : prefix_q);
		acc_new  = {acc_e[23:0], item.data_byte};
		pcnt_new = pcnt_e + 3'd1;
		prefix_done = (pcnt_new >= psize);
		sz       = acc_new;
		rem_dec  = rem_e - 32'd1;
		cap      = (mtu_q >= 16'd3) ? (mtu_q - 16'd2) : 16'd1;
		fill_inc = fill_e + 16'd1;
	end

	// next phase
	always_comb begin
		phase_d = ph_e;
		case (ph_e)
			PH_PREFIX: begin
				if (pos_past) begin
					phase_d = PH_DISCARD;
				end else if (prefix_done) begin
					if (sz == 32'd1) begin
						phase_d = PH_SKIP;
					end else if (sz == 32'd0 || sz > total_e) begin
						phase_d = PH_DISCARD;
					end else begin
						phase_d = PH_NAL;
					end
				end
			end
			PH_SKIP: phase_d = PH_PREFIX;
			PH_NAL: begin
				if (nal_done) begin
					phase_d = PH_PREFIX;
				end
			end
			default: phase_d = ph_e;
		endcase
	end

	// datapath and op issue
	always_comb begin
		pcnt_d  = pcnt_e;
		acc_d   = acc_e;
		rem_d   = rem_e;
		fill_d  = fill_e;
		ind_d   = ind_q;
		type_d  = type_q;
		first_d = first_e;
		fragm_d = fragm_e;
		hp_d    = hp_e;
		nal_done = 1'b0;
		push    = 1'b0;
		op      = '0;
		op.data_byte = item.data_byte;
		op.fu_ind    = ind_q;
		case (ph_e)
			PH_PREFIX: begin
				if (!pos_past) begin
					acc_d  = acc_new;
					pcnt_d = pcnt_new;
					if (prefix_done) begin
						pcnt_d = 3'd0;
						acc_d  = 32'd0;
						if (sz != 32'd1 && sz != 32'd0 && sz <= total_e) begin
							rem_d   = sz;
							fragm_d = (sz > {16'd0, mtu_q});
							hp_d    = (sz > {16'd0, mtu_q});
							fill_d  = 16'd0;
							first_d = 1'b1;
						end
					end
				end
			end
			PH_NAL: begin
				if (!fragm_e) begin
					rem_d   = rem_dec;
					push    = 1'b1;
					op.last = (rem_dec == 32'd0);
				end else if (hp_e) begin
					ind_d   = (item.data_byte & NRI_MASK) | FU_A_TYPE;
					type_d  = item.data_byte[4:0];
					hp_d    = 1'b0;
					first_d = 1'b1;
					fill_d  = 16'd0;
					rem_d   = rem_dec;
				end else begin
					push     = 1'b1;
					op.frag  = 1'b1;
					op.fu_hdr = {3'd0, type_q};
					if (fill_e == 16'd0) begin
						op.with_hdr = 1'b1;
						if (first_e) begin
							op.fu_hdr = op.fu_hdr | FU_S_BIT;
						end
						if (rem_e <= {16'd0, cap}) begin
							op.fu_hdr = op.fu_hdr | FU_E_BIT;
						end
						first_d = 1'b0;
					end
					rem_d   = rem_dec;
					op.last = (rem_dec == 32'd0) || (fill_inc >= cap);
					fill_d  = op.last ? 16'd0 : fill_inc;
				end
				if (rem_d == 32'd0 && !hp_d) begin
					nal_done = 1'b1;
					fragm_d  = 1'b0;
					fill_d   = 16'd0;
				end
			end
			default: ;
		endcase
		push = push & take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX;
			pcnt_q  <= 3'd0;
			acc_q   <= 32'd0;
			rem_q   <= 32'd0;
			idx_q   <= 32'd0;
			total_q <= 32'd0;
			fill_q  <= 16'd0;
			ind_q   <= 8'd0;
			type_q  <= 5'd0;
			first_q <= 1'b1;
			fragm_q <= 1'b0;
			hp_q    <= 1'b0;
		end else if (take) begin
			phase_q <= phase_d;
			pcnt_q  <= pcnt_d;
			acc_q   <= acc_d;
			rem_q   <= rem_d;
			idx_q   <= idx_d;
			total_q <= total_e;
			fill_q  <= fill_d;
			ind_q   <= ind_d;
			type_q  <= type_d;
			first_q <= first_d;
			fragm_q <= fragm_d;
			hp_q    <= hp_d;
		end
	end

	property p_hdr_only_in_nal;
		@(posedge clk) disable iff (!arst_n) hp_q |-> (phase_q == PH_NAL && fragm_q);
	endproperty
	a_hdr_only_in_nal: assert property (p_hdr_only_in_nal)
		else $error("header pending outside fragmented NAL");

endmodule

@@ hw/rtl/fua_fifo.sv @@
// ----------------------------------------------------------------------------
// fua_fifo
// Small op queue between parser and byte emitter.
// ----------------------------------------------------------------------------
module fua_fifo import fua_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  wr_op,
	input  logic pop,
	output op_t  head,
	output logic empty,
	output logic full
);

	op_t              mem_q [QDepth];
	logic [QAw-1:0]   wp_q, rp_q;
	logic [QAw:0]     cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (QAw+1)'(QDepth));
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + QAw'(1);
			end
			if (pop) begin
				rp_q <= rp_q + QAw'(1);
			end
			cnt_q <= cnt_q + (QAw+1)'(push) - (QAw+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QAw+1)'(QDepth))
		else $error("op queue overflow");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + (QAw+1)'(1)))
		else $error("op queue count mismatch");

endmodule

@@ hw/rtl/fua_back.sv @@
// ----------------------------------------------------------------------------
// fua_back
// Byte emitter: expands each op into one or three packet bytes into the
// output register.
// ----------------------------------------------------------------------------
module fua_back import fua_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  op_t       head,
	input  logic      empty,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic [1:0] sub_q;
	logic       load, last_sub;
	out_item_t  sel;
	out_item_t  out_q;
	logic       valid_q;

	assign load     = !empty && (!valid_q || !out_stall);
	assign last_sub = !head.with_hdr || (sub_q == 2'd2);
	assign pop      = load && last_sub;

	always_comb begin
		sel = '{packet_byte: head.data_byte, packet_end: head.last, is_fragment: head.frag};
		if (head.with_hdr) begin
			case (sub_q)
				2'd0: sel = '{packet_byte: head.fu_ind, packet_end: 1'b0, is_fragment: 1'b1};
				2'd1: sel = '{packet_byte: head.fu_hdr, packet_end: 1'b0, is_fragment: 1'b1};
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sub_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sub_q   <= last_sub ? 2'd0 : sub_q + 2'd1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= sel;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = out_q;

	a_sub_range: assert property (@(posedge clk) disable iff (!arst_n)
		(sub_q != 2'd3) && ((sub_q == 2'd0) || (!empty && head.with_hdr)))
		else $error("emitter sub-step out of range");

endmodule

@@ hw/rtl/h264_avc_fu_a_packetizer.sv @@
// ----------------------------------------------------------------------------
// h264_avc_fu_a_packetizer
// AVC length-prefixed H.264 to RTP packet byte stream with FU-A fragmentation.
// Output: each byte passes through the op queue and the output register to
// out_data; a fragment's first byte comes behind its FU indicator and header.
// Throughput: one input byte per cycle while in_stall is low, which it is unless
// the 4-op queue is full; the queue absorbs each fragment's three-byte first op.
// Reset: asynchronous; mtu 1400, prefix 4 bytes, parser waits for frame start.
// ----------------------------------------------------------------------------
module h264_avc_fu_a_packetizer import fua_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic        cfg_we,
	input  cfg_reg_t    cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] mtu_q;
	logic [2:0]  prefix_q;
	logic        take, push, pop, empty, full;
	op_t         op, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mtu_q    <= MTU_RESET;
			prefix_q <= PREFIX_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MTU:    mtu_q    <= cfg_data;
				REG_PREFIX: prefix_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign in_stall = full;
	assign take     = in_valid && !full;

	fua_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.item     (in_data),
		.mtu_q    (mtu_q),
		.prefix_q (prefix_q),
		.push     (push),
		.op       (op)
	);

	fua_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_op  (op),
		.pop    (pop),
		.head   (head),
		.empty  (empty),
		.full   (full)
	);

	fua_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
